// ===== src/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Shared constants, controller states and the command and status bundles
// that join the search controller to the datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

	// Default geometry of the table.
	localparam int DEPTH_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed widths of the port fields.
	localparam int WORD_W  = 32;
	localparam int SLOT_W  = 10;
	localparam int POS_W   = 10;
	localparam int COUNT_W = 11;

	// Request operation codes.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_COMPARE,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic write;     // store the request word in the table
		logic load;      // capture the key and open the search window
		logic issue;     // read the probe entry
		logic step;      // narrow the window after a mismatch
		logic hit;       // record a match at the probe position
		logic miss;      // record a failed search
		logic out_load;  // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;     // window is empty, search has failed
		logic equal;     // probe entry matches the key
		logic less;      // probe entry is below the key
	} sts_t;

endpackage

// ===== src/sorted_table_binary_search.sv =====
// A write request takes effect at its accepting edge and gives no response.
// A search makes at most floor(log2(n))+1 probes for n entries, each a registered read
// and then a compare; it ends on a hit at a matching compare, or on a miss when the window empties.
// Writes are accepted one per cycle while idle; a search stalls requests until its result
// moves to the output register, which waits while an earlier response is stalled.
// Reset clears the controller, the response valid and entry_count; table is unset.
// ----------------------------------------------------------------------------
// Sorted table binary search
// Holds a table of signed entries, sorted ascending, loaded by write
// requests. A search request bisects the first entry_count entries and
// returns a found flag and the matching position.
// ----------------------------------------------------------------------------
module sorted_table_binary_search import stbs_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration: number of entries in use.
	input  logic                cfg_write,
	input  logic [COUNT_W-1:0]  cfg_data,
	// Request channel.
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                op,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [WORD_W-1:0]   word,
	// Response channel.
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic                found,
	output logic [POS_W-1:0]    position
);

	// The controller accepts a request only while idle. A write request is
	// stored in the table at once. A search request opens the window
	// [0, count-1], then alternates between reading the middle entry and
	// comparing it with the key until it matches or the window empties.
	// Each probe is one registered table read, then the compare.
	// The result is held in the datapath until the output register is free,
	// so a new request is accepted while the previous response still waits.
	cmd_t cmd;
	sts_t sts;

	stbs_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (op),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Entries outside the table are never written; counts beyond the table
	// depth are clamped to the depth before a search.
	stbs_datapath #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.slot      (slot),
		.word      (word),
		.cmd       (cmd),
		.sts       (sts),
		.found     (found),
		.position  (position)
	);

endmodule

// ===== src/stbs_datapath.sv =====
// ----------------------------------------------------------------------------
// Search datapath
// Table memory, entry count register, search window and result registers.
// ----------------------------------------------------------------------------
module stbs_datapath import stbs_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [COUNT_W-1:0]  cfg_data,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [WORD_W-1:0]   word,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                found,
	output logic [POS_W-1:0]    position
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int SW = CW + 1;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	logic [COUNT_W-1:0]            count_q;
	logic [CW-1:0]                 count_sat;
	logic [2*WORD_W-1:0]           word_ext;
	logic signed [VALUE_BITS-1:0]  word_val;
	logic [IW+SLOT_W-1:0]          slot_pad;
	logic                          slot_ok;
	logic signed [VALUE_BITS-1:0]  mem_q [DEPTH];
	logic signed [VALUE_BITS-1:0]  rdata_q;
	logic signed [VALUE_BITS-1:0]  key_q;
	logic signed [SW-1:0]          lo_q;
	logic signed [SW-1:0]          hi_q;
	logic signed [SW-1:0]          span;
	logic signed [SW-1:0]          mid;
	logic signed [SW-1:0]          mid_q;
	logic [IW+POS_W-1:0]           mid_pad;
	logic                          res_found_q;
	logic [POS_W-1:0]              res_pos_q;
	logic                          found_q;
	logic [POS_W-1:0]              position_q;

	// The word is sign extended and then wrapped to the entry width.
	assign word_ext = {{WORD_W{word[WORD_W-1]}}, word};
	assign word_val = word_ext[VALUE_BITS-1:0];

	assign slot_pad = {{IW{1'b0}}, slot};
	assign slot_ok  = XW'(slot) < DEPTH_X;

	assign count_sat = (XW'(count_q) > DEPTH_X) ? CW'(DEPTH) : CW'(count_q);

	assign span = hi_q - lo_q;
	assign mid  = lo_q + (span >>> 1);

	assign mid_pad = {{POS_W{1'b0}}, mid_q[IW-1:0]};

	assign sts.empty = lo_q > hi_q;
	assign sts.equal = rdata_q == key_q;
	assign sts.less  = rdata_q < key_q;

	assign found    = found_q;
	assign position = position_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_write) begin
			count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && slot_ok) begin
			mem_q[slot_pad[IW-1:0]] <= word_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rdata_q <= mem_q[mid[IW-1:0]];
			mid_q   <= mid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= word_val;
			lo_q  <= '0;
			hi_q  <= $signed({1'b0, count_sat}) - $signed(SW'(1));
		end else if (cmd.step) begin
			if (sts.less) begin
				lo_q <= mid_q + $signed(SW'(1));
			end else begin
				hi_q <= mid_q - $signed(SW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hit) begin
			res_found_q <= 1'b1;
			res_pos_q   <= mid_pad[POS_W-1:0];
		end else if (cmd.miss) begin
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found_q    <= res_found_q;
			position_q <= res_pos_q;
		end
	end

endmodule

// ===== src/stbs_controller.sv =====
// ----------------------------------------------------------------------------
// Search controller
// State machine that sequences table writes and the probe and compare steps
// of a search, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module stbs_controller import stbs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  logic  op,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	input  sts_t  sts,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid && op == OP_SEARCH) begin
					state_nxt = S_ISSUE;
				end
			end
			S_ISSUE: begin
				state_nxt = sts.empty ? S_FINISH : S_COMPARE;
			end
			S_COMPARE: begin
				state_nxt = sts.equal ? S_FINISH : S_ISSUE;
			end
			S_FINISH: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.write = req_valid && op == OP_WRITE;
				cmd.load  = req_valid && op == OP_SEARCH;
			end
			S_ISSUE: begin
				cmd.issue = !sts.empty;
				cmd.miss  = sts.empty;
			end
			S_COMPARE: begin
				cmd.hit  = sts.equal;
				cmd.step = !sts.equal;
			end
			S_FINISH: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// An accepted search always moves on to the issue state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && op == OP_SEARCH) |=> state_q == S_ISSUE)
		else $error("search request did not start a probe");

	// A write request completes in the cycle it is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && op == OP_WRITE) |=> state_q == S_IDLE)
		else $error("write request left the controller busy");

	// A compare always follows a memory read.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMPARE |-> $past(state_q) == S_ISSUE)
		else $error("compare without a preceding probe read");

	// A finished search waits while an earlier result is still stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && rsp_valid_q && rsp_stall) |=> state_q == S_FINISH)
		else $error("result overwrote a stalled response");
`endif

endmodule
